FILE: sv/twvs_pkg.sv
`timescale 1ns / 1ps
package twvs_pkg;

  localparam int MAX_LAYERS = 32;
  localparam int ADDR_W     = $clog2(MAX_LAYERS);
  localparam int CNT_W      = $clog2(MAX_LAYERS + 1);

  localparam int THK_W   = 24;
  localparam int VEL_W   = 24;
  localparam int LAYER_W = 6;
  localparam int PROD_W  = 48;
  localparam int TOT_W   = 30;
  localparam int FLUX_W  = 56;
  // quotient bits kept by the divider; anything larger saturates anyway
  localparam int QUO_W   = 25;
  localparam int QCNT_W  = $clog2(QUO_W);

  typedef struct packed {
    logic [THK_W-1:0]        thickness_left;
    logic [THK_W-1:0]        thickness_right;
    logic signed [VEL_W-1:0] layer_velocity;
    logic                    edge_mask;
    logic                    first_layer;
    logic                    last_layer;
    logic                    empty_edge;
  } layer_t;

  typedef struct packed {
    logic                    result_kind;
    logic [LAYER_W-1:0]      layer_number;
    logic signed [VEL_W-1:0] velocity_value;
    logic                    overflow;
    logic                    last_result;
  } result_t;

  localparam logic KIND_DEV  = 1'b0;
  localparam logic KIND_MEAN = 1'b1;

  // sequencer steps
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] ST_ACC     = 4'd1;
  localparam logic [PC_W-1:0] ST_DIVINIT = 4'd2;
  localparam logic [PC_W-1:0] ST_DIVSTEP = 4'd3;
  localparam logic [PC_W-1:0] ST_MEAN    = 4'd4;
  localparam logic [PC_W-1:0] ST_READ    = 4'd5;
  localparam logic [PC_W-1:0] ST_EMIT    = 4'd6;
  localparam logic [PC_W-1:0] ST_FINAL   = 4'd7;

  // jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_ALWAYS      = 3'd0;
  localparam logic [COND_W-1:0] C_END_ITEM    = 3'd1;
  localparam logic [COND_W-1:0] C_DIV_SKIP    = 3'd2;
  localparam logic [COND_W-1:0] C_DIV_DONE    = 3'd3;
  localparam logic [COND_W-1:0] C_NO_LAYERS   = 3'd4;
  localparam logic [COND_W-1:0] C_REPLAY_DONE = 3'd5;

  typedef struct packed {
    logic              take_in;
    logic              wait_out;
    logic              acc;
    logic              div_init;
    logic              div_step;
    logic              mean_ld;
    logic              rd;
    logic              emit_dev;
    logic              emit_mean;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic [PC_W-1:0]   alt;
  } uop_t;

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t w;
    w = '0;
    w.cond   = C_ALWAYS;
    w.target = ST_WAIT;
    w.alt    = ST_WAIT;
    case (pc)
      ST_WAIT: begin
        w.take_in = 1'b1;
        w.target  = ST_ACC;
      end
      ST_ACC: begin
        w.acc    = 1'b1;
        w.cond   = C_END_ITEM;
        w.target = ST_DIVINIT;
        w.alt    = ST_WAIT;
      end
      ST_DIVINIT: begin
        w.div_init = 1'b1;
        w.cond     = C_DIV_SKIP;
        w.target   = ST_MEAN;
        w.alt      = ST_DIVSTEP;
      end
      ST_DIVSTEP: begin
        w.div_step = 1'b1;
        w.cond     = C_DIV_DONE;
        w.target   = ST_MEAN;
        w.alt      = ST_DIVSTEP;
      end
      ST_MEAN: begin
        w.mean_ld = 1'b1;
        w.cond    = C_NO_LAYERS;
        w.target  = ST_FINAL;
        w.alt     = ST_READ;
      end
      ST_READ: begin
        w.rd     = 1'b1;
        w.target = ST_EMIT;
      end
      ST_EMIT: begin
        w.wait_out = 1'b1;
        w.emit_dev = 1'b1;
        w.cond     = C_REPLAY_DONE;
        w.target   = ST_FINAL;
        w.alt      = ST_READ;
      end
      ST_FINAL: begin
        w.wait_out  = 1'b1;
        w.emit_mean = 1'b1;
      end
      default: begin
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/twvs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module twvs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/thickness_weighted_velocity_split.sv
// sequence: a layer word is taken, then accumulated; a word without the last mark
//   frees the input again after the accumulate step
// last word: divider set-up, up to 25 divider steps (one quotient bit a cycle), mean,
//   then per stored layer a velocity store read and a deviation result, then the mean result
// empty edge word: take, accumulate, divider set-up, mean, mean result; stall holds replay
// reset: sequencer to wait, sums, count, mask and overflow cleared; velocity store keeps contents
`timescale 1ns / 1ps
`default_nettype none
module thickness_weighted_velocity_split (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              layer_valid,
  output logic                   layer_stall,
  input  wire twvs_pkg::layer_t  layer,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output twvs_pkg::result_t      result
);

  logic [twvs_pkg::PC_W-1:0] pc;
  logic [twvs_pkg::PC_W-1:0] pc_next;
  twvs_pkg::uop_t            uw;

  // registered layer word
  logic [twvs_pkg::THK_W-1:0]         te;
  logic signed [twvs_pkg::PROD_W-1:0] prod;
  logic signed [twvs_pkg::VEL_W-1:0]  vel;
  logic                               item_mask;
  logic                               item_first;
  logic                               item_last;
  logic                               item_empty;

  logic [twvs_pkg::TOT_W-1:0]         thickness_total;
  logic signed [twvs_pkg::FLUX_W-1:0] flux_total;
  logic [twvs_pkg::CNT_W-1:0]         layer_count;
  logic                               mask_held;
  logic                               overflow_seen;

  logic [twvs_pkg::TOT_W-1:0]  rem;
  logic [twvs_pkg::QUO_W-1:0]  quo;
  logic [twvs_pkg::QCNT_W-1:0] div_cnt;
  logic                        div_neg;
  logic                        div_zero;
  logic                        div_big;
  logic signed [twvs_pkg::VEL_W-1:0] mean;
  logic [twvs_pkg::CNT_W-1:0]  k;

  logic [twvs_pkg::VEL_W-1:0]  ram_rdata;

  logic                              take;
  logic                              out_free;
  logic [twvs_pkg::THK_W:0]          thk_sum;
  logic signed [twvs_pkg::PROD_W:0]  prod_full;
  logic [twvs_pkg::CNT_W-1:0]        cnt_base;
  logic                              room;
  logic                              ram_we;
  logic [twvs_pkg::FLUX_W-1:0]       flux_abs;
  logic [twvs_pkg::FLUX_W-twvs_pkg::QUO_W-1:0] flux_hi;
  logic                              big_c;
  logic                              zero_c;
  logic [twvs_pkg::TOT_W:0]          trial;
  logic                              trial_ge;
  logic signed [twvs_pkg::VEL_W:0]   dev_full;
  logic signed [twvs_pkg::VEL_W-1:0] dev_sat;
  logic [twvs_pkg::CNT_W-1:0]        k_inc;
  logic                              cond_hit;
  logic                              hold;

  localparam logic [twvs_pkg::QUO_W-1:0] POS_LIM =
    twvs_pkg::QUO_W'((1 << (twvs_pkg::VEL_W-1)) - 1);
  localparam logic [twvs_pkg::QUO_W-1:0] NEG_LIM =
    twvs_pkg::QUO_W'(1 << (twvs_pkg::VEL_W-1));

  assign uw          = twvs_pkg::uop_rom(pc);
  assign layer_stall = !uw.take_in;
  assign take        = uw.take_in && layer_valid;
  assign out_free    = !result_valid || !result_stall;

  // edge thickness and its flux contribution, straight off the input word
  assign thk_sum   = {1'b0, layer.thickness_left} + {1'b0, layer.thickness_right};
  assign prod_full = $signed({1'b0, thk_sum[twvs_pkg::THK_W:1]}) * layer.layer_velocity;

  assign cnt_base = item_first ? '0 : layer_count;
  assign room     = cnt_base < twvs_pkg::CNT_W'(twvs_pkg::MAX_LAYERS);
  assign ram_we   = uw.acc && !item_empty && room;

  // divider front end: magnitudes, zero and saturation tests
  assign flux_abs = flux_total[twvs_pkg::FLUX_W-1] ? (~flux_total + 1'b1) : flux_total;
  assign flux_hi  = flux_abs[twvs_pkg::FLUX_W-1:twvs_pkg::QUO_W];
  assign zero_c   = (thickness_total == '0);
  assign big_c    = flux_hi >= {1'b0, thickness_total};

  assign trial    = {rem, quo[twvs_pkg::QUO_W-1]};
  assign trial_ge = trial >= {1'b0, thickness_total};

  assign dev_full = $signed({ram_rdata[twvs_pkg::VEL_W-1], ram_rdata})
                    - $signed({mean[twvs_pkg::VEL_W-1], mean});
  assign dev_sat  = (dev_full[twvs_pkg::VEL_W] != dev_full[twvs_pkg::VEL_W-1]) ?
                    (dev_full[twvs_pkg::VEL_W] ? {1'b1, {(twvs_pkg::VEL_W-1){1'b0}}}
                                               : {1'b0, {(twvs_pkg::VEL_W-1){1'b1}}})
                    : dev_full[twvs_pkg::VEL_W-1:0];
  assign k_inc    = k + 1'b1;

  always_comb begin
    case (uw.cond)
      twvs_pkg::C_ALWAYS:      cond_hit = 1'b1;
      twvs_pkg::C_END_ITEM:    cond_hit = item_last || item_empty;
      twvs_pkg::C_DIV_SKIP:    cond_hit = zero_c || big_c;
      twvs_pkg::C_DIV_DONE:    cond_hit = (div_cnt == '0);
      twvs_pkg::C_NO_LAYERS:   cond_hit = (layer_count == '0);
      twvs_pkg::C_REPLAY_DONE: cond_hit = (k_inc == layer_count);
      default:                 cond_hit = 1'b1;
    endcase
    hold = (uw.take_in && !layer_valid) || (uw.wait_out && !out_free);
    if (hold) begin
      pc_next = pc;
    end else if (cond_hit) begin
      pc_next = uw.target;
    end else begin
      pc_next = uw.alt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= twvs_pkg::ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      te         <= thk_sum[twvs_pkg::THK_W:1];
      prod       <= prod_full[twvs_pkg::PROD_W-1:0];
      vel        <= layer.layer_velocity;
      item_mask  <= layer.edge_mask;
      item_first <= layer.first_layer;
      item_last  <= layer.last_layer;
      item_empty <= layer.empty_edge;
    end
  end

  // edge sums
  always_ff @(posedge clk) begin
    if (rst) begin
      thickness_total <= '0;
      flux_total      <= '0;
      layer_count     <= '0;
      mask_held       <= 1'b0;
      overflow_seen   <= 1'b0;
    end else if (uw.acc) begin
      if (item_empty) begin
        thickness_total <= '0;
        flux_total      <= '0;
        layer_count     <= '0;
        mask_held       <= 1'b0;
        overflow_seen   <= 1'b0;
      end else begin
        if (item_first) begin
          mask_held <= item_mask;
        end
        if (room) begin
          thickness_total <= (item_first ? '0 : thickness_total)
                             + {{(twvs_pkg::TOT_W-twvs_pkg::THK_W){1'b0}}, te};
          flux_total      <= (item_first ? '0 : flux_total)
                             + {{(twvs_pkg::FLUX_W-twvs_pkg::PROD_W){prod[twvs_pkg::PROD_W-1]}}, prod};
          layer_count     <= cnt_base + 1'b1;
          overflow_seen   <= item_first ? 1'b0 : overflow_seen;
        end else begin
          // dropped layer
          overflow_seen <= 1'b1;
        end
      end
    end else if (uw.emit_mean && out_free) begin
      thickness_total <= '0;
      flux_total      <= '0;
      layer_count     <= '0;
      mask_held       <= 1'b0;
      overflow_seen   <= 1'b0;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (uw.div_init) begin
      rem      <= flux_hi[twvs_pkg::TOT_W-1:0];
      quo      <= flux_abs[twvs_pkg::QUO_W-1:0];
      div_cnt  <= twvs_pkg::QCNT_W'(twvs_pkg::QUO_W - 1);
      div_neg  <= flux_total[twvs_pkg::FLUX_W-1];
      div_zero <= zero_c;
      div_big  <= big_c;
    end else if (uw.div_step) begin
      rem     <= trial_ge ? twvs_pkg::TOT_W'(trial - {1'b0, thickness_total})
                          : trial[twvs_pkg::TOT_W-1:0];
      quo     <= {quo[twvs_pkg::QUO_W-2:0], trial_ge};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.mean_ld) begin
      if (div_zero) begin
        mean <= '0;
      end else if (div_neg) begin
        if (div_big || quo > NEG_LIM) begin
          mean <= {1'b1, {(twvs_pkg::VEL_W-1){1'b0}}};
        end else begin
          mean <= twvs_pkg::VEL_W'(~quo + 1'b1);
        end
      end else begin
        if (div_big || quo > POS_LIM) begin
          mean <= {1'b0, {(twvs_pkg::VEL_W-1){1'b1}}};
        end else begin
          mean <= quo[twvs_pkg::VEL_W-1:0];
        end
      end
    end
  end

  // replay index
  always_ff @(posedge clk) begin
    if (uw.mean_ld) begin
      k <= '0;
    end else if (uw.emit_dev && out_free) begin
      k <= k_inc;
    end
  end

  twvs_ram #(
    .WIDTH(twvs_pkg::VEL_W),
    .DEPTH(twvs_pkg::MAX_LAYERS)
  ) u_vel_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_base[twvs_pkg::ADDR_W-1:0]),
    .wdata(vel),
    .re   (uw.rd),
    .raddr(k[twvs_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free && (uw.emit_dev || uw.emit_mean)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && uw.emit_dev) begin
      result.result_kind    <= twvs_pkg::KIND_DEV;
      result.layer_number   <= twvs_pkg::LAYER_W'(k);
      result.velocity_value <= dev_sat;
      result.overflow       <= overflow_seen;
      result.last_result    <= 1'b0;
    end else if (out_free && uw.emit_mean) begin
      result.result_kind    <= twvs_pkg::KIND_MEAN;
      result.layer_number   <= '0;
      result.velocity_value <= mask_held ? mean : '0;
      result.overflow       <= overflow_seen;
      result.last_result    <= 1'b1;
    end
  end

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    layer_count <= twvs_pkg::CNT_W'(twvs_pkg::MAX_LAYERS))
    else $error("layer count beyond capacity");

  a_last_is_mean: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last_result == result.result_kind))
    else $error("last word and mean word disagree");

  a_replay_range: assert property (@(posedge clk) disable iff (rst)
    (pc == twvs_pkg::ST_EMIT) |-> (k < layer_count))
    else $error("replay index past stored layers");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (pc == twvs_pkg::ST_DIVSTEP) |-> (!div_zero && !div_big))
    else $error("divider stepping on a skipped division");

  a_edge_cleared: assert property (@(posedge clk) disable iff (rst)
    (pc == twvs_pkg::ST_FINAL && out_free) |=> (layer_count == '0 && !overflow_seen))
    else $error("edge state not cleared after mean word");
`endif

endmodule
`default_nettype wire
